// ===== rtl/core/joystick_cursor_tracker_assert.svh =====
// Assertion macros for the joystick cursor tracker checker.
`ifndef JOYSTICK_CURSOR_TRACKER_ASSERT_SVH
`define JOYSTICK_CURSOR_TRACKER_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define JCT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("joystick cursor tracker assertion failed");

// Consequent checked in the same cycle as the antecedent.
`define JCT_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("joystick cursor tracker assertion failed");

`endif

// ===== rtl/core/jct_pkg.sv =====
package jct_pkg;

	localparam int ADC_BITS      = 12;
	localparam int CALIB_SAMPLES = 8;

	localparam int POS_X_W    = 7;
	localparam int POS_Y_W    = 6;
	localparam int POS_X_MAX  = 127;
	localparam int POS_Y_MAX  = 63;
	localparam int POS_X_HOME = 64;
	localparam int POS_Y_HOME = 32;

	localparam int SENS_W    = 2;
	localparam int DZ_W      = 12;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 1'b1;

	localparam logic [SENS_W-1:0] SENS_SLOW  = 2'd0;
	localparam logic [SENS_W-1:0] SENS_MID   = 2'd1;
	localparam logic [SENS_W-1:0] SENS_FAST  = 2'd2;
	localparam int                DZ_RESET   = 180;

	localparam int DIV_W        = 10;
	localparam int DIVISOR_SLOW = 900;
	localparam int DIVISOR_MID  = 700;
	localparam int DIVISOR_FAST = 500;

	localparam int QW_RAW = $clog2((2 ** ADC_BITS - 1) / DIVISOR_FAST + 1);
	localparam int QW     = (QW_RAW < 2) ? 2 : QW_RAW;
	localparam int QIW    = $clog2(QW);

	localparam int SUM_W = ADC_BITS + $clog2(CALIB_SAMPLES);
	localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);

	localparam int EW = ((ADC_BITS > DZ_W) ? ADC_BITS : DZ_W) + 2;
	localparam int MW = ((QW + 1 > POS_X_W) ? QW + 1 : POS_X_W) + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV_X,
		ST_DIV_Y,
		ST_WRITE
	} jct_state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic div_start;
		logic div_sel_y;
		logic take_qx;
		logic commit;
	} jct_cmd_t;

	typedef struct packed {
		logic item_done;
		logic div_done;
		logic out_free;
	} jct_stat_t;

	function automatic logic [DIV_W-1:0] divisor_for(input logic [SENS_W-1:0] sens);
		logic [DIV_W-1:0] d;
		case (sens)
			SENS_SLOW: d = DIV_W'(DIVISOR_SLOW);
			SENS_FAST: d = DIV_W'(DIVISOR_FAST);
			default:   d = DIV_W'(DIVISOR_MID);
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/core/jct_in_if.sv =====
interface jct_in_if;
	import jct_pkg::*;

	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] sample_x;
	logic [ADC_BITS-1:0] sample_y;
	logic                read_ok;
	logic                button_level;
	logic                enabled;

	modport source (
		output valid, sample_x, sample_y, read_ok, button_level, enabled,
		input  ready
	);
	modport sink (
		input  valid, sample_x, sample_y, read_ok, button_level, enabled,
		output ready
	);
endinterface

// ===== rtl/core/jct_out_if.sv =====
interface jct_out_if;
	import jct_pkg::*;

	logic               valid;
	logic               ready;
	logic [POS_X_W-1:0] cur_col;
	logic [POS_Y_W-1:0] cur_row;
	logic               btn_down;
	logic               wake;

	modport source (
		output valid, cur_col, cur_row, btn_down, wake,
		input  ready
	);
	modport sink (
		input  valid, cur_col, cur_row, btn_down, wake,
		output ready
	);
endinterface

// ===== rtl/core/jct_div.sv =====
module jct_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [jct_pkg::ADC_BITS-1:0] num,
	input  logic [jct_pkg::DIV_W-1:0]    den,
	output logic                         done,
	output logic [jct_pkg::QW-1:0]       quot
);
	import jct_pkg::*;

	localparam int TW = ADC_BITS + QW;

	logic                running_q;
	logic                done_q;
	logic [QIW-1:0]      cnt_q;
	logic [ADC_BITS-1:0] rem_q;
	logic [QW-1:0]       quot_q;
	logic [TW-1:0]       trial;
	logic                fits;

	always_comb begin
		trial = TW'(den) << cnt_q;
		fits  = TW'(rem_q) >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else if (start) begin
			running_q <= 1'b1;
			done_q    <= 1'b0;
			cnt_q     <= QIW'(QW - 1);
		end else if (running_q) begin
			if (cnt_q == '0) begin
				running_q <= 1'b0;
				done_q    <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			quot_q <= '0;
		end else if (running_q) begin
			if (fits) begin
				rem_q <= rem_q - trial[ADC_BITS-1:0];
			end
			quot_q <= {quot_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

// ===== rtl/core/jct_datapath.sv =====
module jct_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  jct_pkg::jct_cmd_t            cmd,
	output jct_pkg::jct_stat_t           stat,
	input  logic [jct_pkg::ADC_BITS-1:0] sample_x,
	input  logic [jct_pkg::ADC_BITS-1:0] sample_y,
	input  logic                         read_ok,
	input  logic                         button_level,
	input  logic                         enabled,
	input  logic                         cfg_we,
	input  logic [jct_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jct_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [jct_pkg::POS_X_W-1:0]  cur_col,
	output logic [jct_pkg::POS_Y_W-1:0]  cur_row,
	output logic                         btn_down,
	output logic                         wake
);
	import jct_pkg::*;

	logic [ADC_BITS-1:0] sx_q, sy_q;
	logic                ok_q, btn_q, en_q;

	logic [SENS_W-1:0]   sens_q;
	logic [DZ_W-1:0]     dz_q;
	logic [ADC_BITS-1:0] centre_x_q, centre_y_q;
	logic [SUM_W-1:0]    sum_x_q, sum_y_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                calib_q;
	logic [POS_X_W-1:0]  pos_x_q;
	logic [POS_Y_W-1:0]  pos_y_q;
	logic                last_btn_q, pressed_q, last_en_q;
	logic                out_valid_q;
	logic [QW-1:0]       qx_q;

	logic [POS_X_W-1:0]  out_x_q;
	logic [POS_Y_W-1:0]  out_y_q;
	logic                out_pressed_q, out_wake_q;

	logic                rise;
	logic [SUM_W-1:0]    base_x, base_y, sum_x_next, sum_y_next;
	logic [CNT_W-1:0]    cnt_next;
	logic                calib_end;

	logic signed [EW-1:0] dx, dy, dz_s, mag_x, mag_y;
	logic                 x_pos, x_neg, y_pos, y_neg;
	logic [ADC_BITS-1:0]  num_x, num_y;

	logic                div_done;
	logic [QW-1:0]       quot;

	logic [MW-1:0]       step_x, step_y, sum_x, sum_y;
	logic                mv_x_dn, mv_x_up, mv_y_up, mv_y_dn, moved_x, moved_y;
	logic [POS_X_W-1:0]  px_next;
	logic [POS_Y_W-1:0]  py_next;
	logic                press, release_b, changed, pressed_next, wake_next;

	// calibration accumulate
	always_comb begin
		rise       = en_q & ~last_en_q;
		base_x     = rise ? '0 : sum_x_q;
		base_y     = rise ? '0 : sum_y_q;
		sum_x_next = base_x + (ok_q ? SUM_W'(sx_q) : '0);
		sum_y_next = base_y + (ok_q ? SUM_W'(sy_q) : '0);
		cnt_next   = (rise ? '0 : cnt_q) + 1'b1;
		calib_end  = cnt_next >= CNT_W'(CALIB_SAMPLES);
	end

	// deviation from centre against the dead zone
	always_comb begin
		dz_s  = $signed(EW'(dz_q));
		dx    = $signed(EW'(sx_q)) - $signed(EW'(centre_x_q));
		dy    = $signed(EW'(sy_q)) - $signed(EW'(centre_y_q));
		x_pos = dx > dz_s;
		x_neg = dx < -dz_s;
		y_pos = dy > dz_s;
		y_neg = dy < -dz_s;
		mag_x = dx[EW-1] ? -dx : dx;
		mag_y = dy[EW-1] ? -dy : dy;
		num_x = (x_pos | x_neg) ? ADC_BITS'(mag_x - dz_s) : '0;
		num_y = (y_pos | y_neg) ? ADC_BITS'(mag_y - dz_s) : '0;
	end

	jct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cmd.div_sel_y ? num_y : num_x),
		.den    (divisor_for(sens_q)),
		.done   (div_done),
		.quot   (quot)
	);

	// cursor step, X inverted, then clamp
	always_comb begin
		step_x  = MW'(qx_q) + MW'(1);
		step_y  = MW'(quot) + MW'(1);
		mv_x_dn = x_pos & (pos_x_q != '0);
		mv_x_up = x_neg & (pos_x_q != POS_X_W'(POS_X_MAX));
		mv_y_up = y_pos & (pos_y_q != POS_Y_W'(POS_Y_MAX));
		mv_y_dn = y_neg & (pos_y_q != '0);
		moved_x = mv_x_dn | mv_x_up;
		moved_y = mv_y_up | mv_y_dn;
		sum_x   = mv_x_dn ? MW'(pos_x_q) - step_x : MW'(pos_x_q) + step_x;
		sum_y   = mv_y_dn ? MW'(pos_y_q) - step_y : MW'(pos_y_q) + step_y;

		if (!moved_x) begin
			px_next = pos_x_q;
		end else if (sum_x[MW-1]) begin
			px_next = '0;
		end else if (sum_x > MW'(POS_X_MAX)) begin
			px_next = POS_X_W'(POS_X_MAX);
		end else begin
			px_next = sum_x[POS_X_W-1:0];
		end

		if (!moved_y) begin
			py_next = pos_y_q;
		end else if (sum_y[MW-1]) begin
			py_next = '0;
		end else if (sum_y > MW'(POS_Y_MAX)) begin
			py_next = POS_Y_W'(POS_Y_MAX);
		end else begin
			py_next = sum_y[POS_Y_W-1:0];
		end

		press        = ~btn_q & last_btn_q;
		release_b    = btn_q & ~last_btn_q;
		changed      = press | release_b;
		pressed_next = press ? 1'b1 : (release_b ? 1'b0 : pressed_q);
		wake_next    = en_q & (moved_x | moved_y | changed);
	end

	always_comb begin
		stat.item_done = rise | calib_q | ~ok_q;
		stat.div_done  = div_done;
		stat.out_free  = ~out_valid_q | out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q  <= sample_x;
			sy_q  <= sample_y;
			ok_q  <= read_ok;
			btn_q <= button_level;
			en_q  <= enabled;
		end
		if (cmd.take_qx) begin
			qx_q <= quot;
		end
		if (cmd.commit) begin
			out_x_q       <= px_next;
			out_y_q       <= py_next;
			out_pressed_q <= pressed_next;
			out_wake_q    <= wake_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q      <= SENS_MID;
			dz_q        <= DZ_W'(DZ_RESET);
			centre_x_q  <= '0;
			centre_y_q  <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			cnt_q       <= '0;
			calib_q     <= 1'b1;
			pos_x_q     <= POS_X_W'(POS_X_HOME);
			pos_y_q     <= POS_Y_W'(POS_Y_HOME);
			last_btn_q  <= 1'b1;
			pressed_q   <= 1'b0;
			last_en_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SENSITIVITY: sens_q <= cfg_wdata[SENS_W-1:0];
					CFG_DEAD_ZONE:   dz_q   <= cfg_wdata[DZ_W-1:0];
					default:         ;
				endcase
			end
			if (cmd.eval) begin
				last_en_q <= en_q;
				if (rise | calib_q) begin
					sum_x_q <= sum_x_next;
					sum_y_q <= sum_y_next;
					cnt_q   <= cnt_next;
					calib_q <= ~calib_end;
					if (calib_end) begin
						centre_x_q <= ADC_BITS'(sum_x_next / CALIB_SAMPLES);
						centre_y_q <= ADC_BITS'(sum_y_next / CALIB_SAMPLES);
						pos_x_q    <= POS_X_W'(POS_X_HOME);
						pos_y_q    <= POS_Y_W'(POS_Y_HOME);
					end
				end
			end
			if (cmd.commit) begin
				pos_x_q    <= px_next;
				pos_y_q    <= py_next;
				last_btn_q <= btn_q;
				pressed_q  <= pressed_next;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign cur_col   = out_x_q;
	assign cur_row   = out_y_q;
	assign btn_down  = out_pressed_q;
	assign wake      = out_wake_q;
endmodule

// ===== rtl/core/jct_ctrl.sv =====
module jct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output jct_pkg::jct_cmd_t  cmd,
	input  jct_pkg::jct_stat_t stat
);
	import jct_pkg::*;

	jct_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.item_done) begin
					state_next = ST_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_next    = ST_DIV_X;
				end
			end
			ST_DIV_X: begin
				if (stat.div_done) begin
					cmd.take_qx   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel_y = 1'b1;
					state_next    = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				if (stat.div_done) begin
					state_next = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end
endmodule

// ===== rtl/core/joystick_cursor_tracker.sv =====
// Joystick cursor tracker.
// in_ch carries one joystick sample per beat (X/Y samples, read_ok, button level,
// enabled); out_ch carries one cursor beat (cur_col, cur_row, btn_down,
// wake) for each good sample taken outside calibration. Calibration samples and
// failed reads give no output beat.
// cfg_we/cfg_index/cfg_wdata write sensitivity (index 0) and dead_zone (index 1);
// write only while the block is idle.
// A good sample goes through the eval step, two passes of the shared serial
// divider (X, then Y), one quotient bit per cycle, and the write step before
// it is on out_ch. The input is ready again in the same cycle that the output
// beat appears; calibration samples and failed reads return to idle after the
// eval step.
// Reset: sensitivity 1, dead zone 180, cursor at 64,32, and the next 8 samples
// calibrate the centre. A rise of enabled restarts calibration.
// A stalled out_ch holds its beat in the output register; the next sample is
// still taken and worked on, and waits at the write step until out_ch is free.
module joystick_cursor_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	jct_in_if.sink                         in_ch,
	jct_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [jct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jct_pkg::CFG_W-1:0]      cfg_wdata
);
	import jct_pkg::*;

	jct_cmd_t  cmd;
	jct_stat_t stat;
	logic      in_ready;

	jct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	jct_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample_x     (in_ch.sample_x),
		.sample_y     (in_ch.sample_y),
		.read_ok      (in_ch.read_ok),
		.button_level (in_ch.button_level),
		.enabled      (in_ch.enabled),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.cur_col      (out_ch.cur_col),
		.cur_row      (out_ch.cur_row),
		.btn_down     (out_ch.btn_down),
		.wake         (out_ch.wake)
	);

	assign in_ch.ready = in_ready;
endmodule

// ===== rtl/core/jct_checker.sv =====
`include "joystick_cursor_tracker_assert.svh"

module jct_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [jct_pkg::POS_X_W-1:0]   cur_col,
	input logic [jct_pkg::POS_Y_W-1:0]   cur_row,
	input logic                          btn_down,
	input logic                          wake
);
	import jct_pkg::*;

	logic [POS_X_W+POS_Y_W+1:0] out_payload;

	assign out_payload = {cur_col, cur_row, btn_down, wake};

	`JCT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`JCT_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_payload))
	`JCT_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)
	`JCT_ASSERT_SAME(a_out_after_work, clk, arst_n, $rose(out_valid), $past(!in_ready))
endmodule

bind joystick_cursor_tracker jct_checker u_jct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.cur_col   (out_ch.cur_col),
	.cur_row   (out_ch.cur_row),
	.btn_down  (out_ch.btn_down),
	.wake      (out_ch.wake)
);
